>>> rtl/nbf_pkg.sv
// ----------------------------------------------------------------------------
// nbf_pkg: shared types, constants and functions of the note-off byte framer
// Field widths, message layout, CRC-8 step and the message packer.
// ----------------------------------------------------------------------------
package nbf_pkg;

  localparam int MAX_PAYLOAD_DEF = 256;

  localparam int TAG_W  = 8;
  localparam int CNT_W  = 9;
  localparam int BYTE_W = 8;
  localparam int DATA_W = 7;

  // request codes
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_DATA  = 1'b1;

  localparam logic [7:0] CRC_INIT    = 8'hff;
  localparam logic [7:0] CRC_POLY    = 8'h8c;
  localparam logic [7:0] STATUS_BASE = 8'h80;
  localparam logic [7:0] TAG_SHORT   = 8'h80;
  localparam logic [7:0] FLAG_START  = 8'h08;
  localparam logic [7:0] FLAG_TWO    = 8'h04;
  localparam logic [7:0] FLAG_HI1    = 8'h02;
  localparam logic [7:0] FLAG_HI2    = 8'h01;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0]        status_byte;
    logic [DATA_W-1:0] first_data;
    logic [DATA_W-1:0] second_data;
    logic              last;
  } msg_t;

  // captured request, with the tag already adjusted and its CRC taken
  typedef struct packed {
    logic             req_type;
    logic [TAG_W-1:0] tag_sent;
    logic [CNT_W-1:0] count;
    logic [BYTE_W-1:0] data_byte;
    logic [7:0]       crc_tag;
  } staged_t;

  typedef struct packed {
    logic [1:0] n;
    msg_t       m0;
    msg_t       m1;
  } push_t;

  // one byte of reflected CRC-8
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic msg_t msg_pack(input logic [7:0] b1, input logic two,
                                    input logic [7:0] b2, input logic start,
                                    input logic last);
    msg_t m;
    logic [7:0] ch;
    ch = start ? FLAG_START : 8'h00;
    if (b1[7]) ch = ch | FLAG_HI1;
    if (two) begin
      ch = ch | FLAG_TWO;
      if (b2[7]) ch = ch | FLAG_HI2;
    end
    m.status_byte = STATUS_BASE | ch;
    m.first_data  = b1[DATA_W-1:0];
    m.second_data = two ? b2[DATA_W-1:0] : '0;
    m.last        = last;
    return m;
  endfunction

endpackage

>>> rtl/nbf_channels.sv
// ----------------------------------------------------------------------------
// nbf channels: request and message stream interfaces
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
interface nbf_in_if import nbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              req_type;
  logic [TAG_W-1:0]  tag;
  logic [CNT_W-1:0]  payload_count;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, req_type, tag, payload_count, data_byte, input ready);
  modport sink   (input valid, req_type, tag, payload_count, data_byte, output ready);
endinterface

interface nbf_out_if import nbf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [7:0]        status_byte;
  logic [DATA_W-1:0] first_data;
  logic [DATA_W-1:0] second_data;
  logic              last;

  modport source (output valid, status_byte, first_data, second_data, last, input ready);
  modport sink   (input valid, status_byte, first_data, second_data, last, output ready);
endinterface

>>> rtl/nbf_capture.sv
// ----------------------------------------------------------------------------
// nbf_capture: request input register
// Saturates the count, marks short tags and takes the CRC over the tag.
// ----------------------------------------------------------------------------
module nbf_capture import nbf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic    clk,
  input  logic    rst,
  nbf_in_if.sink  in_ch,
  input  logic    room,
  output logic    stg_valid,
  output staged_t stg
);

  logic    ir_valid;
  staged_t ir;
  staged_t ir_next;
  logic [CNT_W-1:0] cnt_sat;
  logic             is_short;

  assign in_ch.ready = !ir_valid || room;
  assign stg_valid   = ir_valid;
  assign stg         = ir;

  always_comb begin
    cnt_sat = (in_ch.payload_count > CNT_W'(MAX_PAYLOAD)) ? CNT_W'(MAX_PAYLOAD)
                                                         : in_ch.payload_count;
    is_short = (cnt_sat <= CNT_W'(1));
    ir_next.req_type  = in_ch.req_type;
    ir_next.tag_sent  = is_short ? (in_ch.tag | TAG_SHORT) : in_ch.tag;
    ir_next.count     = cnt_sat;
    ir_next.data_byte = in_ch.data_byte;
    ir_next.crc_tag   = crc8_step(CRC_INIT, ir_next.tag_sent);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_valid <= 1'b0;
    end else if (in_ch.ready) begin
      ir_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ir <= ir_next;
    end
  end

  a_capture_fill: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> ir_valid)
    else $error("accepted request not held in input register");

endmodule

>>> rtl/nbf_core.sv
// ----------------------------------------------------------------------------
// nbf_core: command state and message builder
// Tracks the open command, pairs payload bytes and appends the CRC.
// ----------------------------------------------------------------------------
module nbf_core import nbf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    stg_valid,
  input  staged_t stg,
  input  logic    room,
  output push_t   push
);

  localparam int BL_W = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]        crc_value, crc_value_next;
  logic [BYTE_W-1:0] pending_byte, pending_byte_next;
  logic              pending_valid, pending_valid_next;
  logic [BL_W-1:0]   bytes_left, bytes_left_next;

  logic            fire;
  logic [7:0]      len;
  logic [7:0]      crc_n;
  logic [BL_W-1:0] bl_dec;
  logic            is_short;

  assign fire     = stg_valid && room;
  assign is_short = (stg.count <= CNT_W'(1));

  always_comb begin
    push               = '0;
    crc_value_next     = crc_value;
    pending_byte_next  = pending_byte;
    pending_valid_next = pending_valid;
    bytes_left_next    = bytes_left;
    len                = '0;
    crc_n              = crc_value;
    bl_dec             = bytes_left - BL_W'(1);
    if (fire) begin
      if (stg.req_type == REQ_START) begin
        if (is_short) begin
          len = (stg.count == CNT_W'(1)) ? stg.data_byte : 8'h00;
        end else begin
          len = 8'(stg.count - CNT_W'(1));
        end
        crc_n              = crc8_step(stg.crc_tag, len);
        crc_value_next     = crc_n;
        pending_valid_next = 1'b0;
        pending_byte_next  = '0;
        push.m0 = msg_pack(stg.tag_sent, 1'b1, len, 1'b1, 1'b0);
        if (is_short) begin
          push.m1         = msg_pack(crc_n, 1'b0, 8'h00, 1'b0, 1'b1);
          push.n          = 2'd2;
          bytes_left_next = '0;
        end else begin
          push.n          = 2'd1;
          bytes_left_next = BL_W'(stg.count);
        end
      end else if (bytes_left != '0) begin
        crc_n           = crc8_step(crc_value, stg.data_byte);
        crc_value_next  = crc_n;
        bytes_left_next = bl_dec;
        if (pending_valid) begin
          push.m0            = msg_pack(pending_byte, 1'b1, stg.data_byte, 1'b0, 1'b0);
          push.n             = 2'd1;
          pending_valid_next = 1'b0;
          pending_byte_next  = '0;
          if (bl_dec == '0) begin
            push.m1 = msg_pack(crc_n, 1'b0, 8'h00, 1'b0, 1'b1);
            push.n  = 2'd2;
          end
        end else if (bl_dec == '0) begin
          // odd byte at the end: pair it with the CRC
          push.m0            = msg_pack(stg.data_byte, 1'b1, crc_n, 1'b0, 1'b1);
          push.n             = 2'd1;
          pending_valid_next = 1'b0;
          pending_byte_next  = '0;
        end else begin
          pending_valid_next = 1'b1;
          pending_byte_next  = stg.data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_value     <= CRC_INIT;
      pending_byte  <= '0;
      pending_valid <= 1'b0;
      bytes_left    <= '0;
    end else begin
      crc_value     <= crc_value_next;
      pending_byte  <= pending_byte_next;
      pending_valid <= pending_valid_next;
      bytes_left    <= bytes_left_next;
    end
  end

  a_pending_open: assert property (@(posedge clk) disable iff (rst)
    pending_valid |-> (bytes_left != '0))
    else $error("pending byte held with no command open");

  a_short_two_msgs: assert property (@(posedge clk) disable iff (rst)
    (fire && stg.req_type == REQ_START && is_short) |-> (push.n == 2'd2))
    else $error("short command did not emit start and CRC messages");

endmodule

>>> rtl/nbf_queue.sv
// ----------------------------------------------------------------------------
// nbf_queue: result message queue
// Takes up to two messages per cycle, sends one per transfer.
// ----------------------------------------------------------------------------
module nbf_queue import nbf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  output logic      room,
  nbf_out_if.source out_ch
);

  msg_t            mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, rd_ptr;
  logic [Q_CW-1:0] count, count_next;
  logic            pop;
  msg_t            head;

  assign room         = (count <= Q_CW'(Q_DEPTH - 2));
  assign pop          = out_ch.valid && out_ch.ready;
  assign head         = mem[rd_ptr];
  assign out_ch.valid = (count != '0);
  assign out_ch.status_byte = head.status_byte;
  assign out_ch.first_data  = head.first_data;
  assign out_ch.second_data = head.second_data;
  assign out_ch.last        = head.last;

  assign count_next = count + Q_CW'(push.n) - Q_CW'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_AW'(push.n);
      if (pop) rd_ptr <= rd_ptr + Q_AW'(1);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr_ptr] <= push.m0;
    if (push.n == 2'd2) mem[wr_ptr + Q_AW'(1)] <= push.m1;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CW'(Q_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> room)
    else $error("messages pushed without room");

endmodule

>>> rtl/noteoff_byte_framer_crc8.sv
// A request passes the input register, then the result queue, before its messages leave.
// Throughput: one request per cycle while the four-entry result queue has room for two;
//   messages leave one per cycle while out_ch.ready is high.
// Requests that produce no message (stray payload) still wait for room in the queue.
// Reset (rst, synchronous): CRC to 0xff, no command open, nothing pending, queue empty.
// ----------------------------------------------------------------------------
// noteoff_byte_framer_crc8: note-off message framer with CRC-8
// Packs tagged commands into three-byte note-off messages and appends a CRC.
// ----------------------------------------------------------------------------
module noteoff_byte_framer_crc8 import nbf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic      clk,
  input  logic      rst,
  nbf_in_if.sink    in_ch,
  nbf_out_if.source out_ch
);

  logic    room;
  logic    stg_valid;
  staged_t stg;
  push_t   push;

  nbf_capture #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_capture (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .room      (room),
    .stg_valid (stg_valid),
    .stg       (stg)
  );

  nbf_core #(.MAX_PAYLOAD(MAX_PAYLOAD)) u_core (
    .clk       (clk),
    .rst       (rst),
    .stg_valid (stg_valid),
    .stg       (stg),
    .room      (room),
    .push      (push)
  );

  nbf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule
